[hw/rtl/anchor_box_decoder_defines.svh]
// Assertion macros shared by the anchor box decoder RTL.
`ifndef ANCHOR_BOX_DECODER_DEFINES_SVH
`define ANCHOR_BOX_DECODER_DEFINES_SVH

// Same-cycle implication, clocked on clk, muted while rst_n is low
`define ABD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("anchor box decoder: same-cycle check failed");

// Next-cycle implication, clocked on clk, muted while rst_n is low
`define ABD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("anchor box decoder: next-cycle check failed");

`endif

[hw/rtl/abd_pkg.sv]
// Types, widths and constant tables of the anchor box decoder.
`timescale 1ns / 1ps
`default_nettype none

package abd_pkg;

    // Coordinate and operand widths
    localparam int COORD_WIDTH     = 16;
    localparam int RAW_WIDTH       = 16;
    localparam int VAR_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    // Register stages from input to output register
    localparam int NUM_STAGES = 6;

    // Centre result (Q.F, a few guard bits) and signed half size widths
    localparam int CENTER_W = COORD_WIDTH + 7;
    localparam int HALF_W   = COORD_WIDTH + 24;

    // log2(e) in Q.16
    localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

    // 2^(i/16) in Q.16 and the step to the next entry
    localparam logic [16:0] POW2_BASE [0:15] = '{
        17'd65536,  17'd68438,  17'd71468,  17'd74632,
        17'd77936,  17'd81386,  17'd84990,  17'd88753,
        17'd92682,  17'd96785,  17'd101070, 17'd105545,
        17'd110218, 17'd115098, 17'd120194, 17'd125515
    };
    localparam logic [12:0] POW2_STEP [0:15] = '{
        13'd2902, 13'd3030, 13'd3164, 13'd3304,
        13'd3450, 13'd3604, 13'd3763, 13'd3929,
        13'd4103, 13'd4285, 13'd4475, 13'd4673,
        13'd4880, 13'd5096, 13'd5321, 13'd5557
    };

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_VAR_CENTER_X = 3'd0,
        REG_VAR_CENTER_Y = 3'd1,
        REG_VAR_WIDTH    = 3'd2,
        REG_VAR_HEIGHT   = 3'd3
    } cfg_reg_t;

    // Input transaction
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] anchor_xmin;
        logic signed [COORD_WIDTH-1:0] anchor_ymin;
        logic signed [COORD_WIDTH-1:0] anchor_xmax;
        logic signed [COORD_WIDTH-1:0] anchor_ymax;
        logic signed [RAW_WIDTH-1:0]   raw_dx;
        logic signed [RAW_WIDTH-1:0]   raw_dy;
        logic signed [RAW_WIDTH-1:0]   raw_dw;
        logic signed [RAW_WIDTH-1:0]   raw_dh;
    } abd_in_t;

    // Output transaction
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] box_xmin;
        logic signed [COORD_WIDTH-1:0] box_ymin;
        logic signed [COORD_WIDTH-1:0] box_xmax;
        logic signed [COORD_WIDTH-1:0] box_ymax;
        logic                          saturated;
    } abd_out_t;

    // Stage load enables and occupancy
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } abd_pipe_t;

endpackage

`default_nettype wire

[hw/rtl/abd_pipe_ctrl.sv]
// Valid tracking and stall control of the decoder pipeline.
`timescale 1ns / 1ps
`default_nettype none

module abd_pipe_ctrl
    import abd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic out_ready,
    output logic      out_valid,
    output abd_pipe_t pipe
);

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    // A stage loads when it is empty or its content moves on
    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    // Valid bits follow the data
    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NUM_STAGES-1];
    assign pipe.en   = en;
    assign pipe.vld  = vld_reg;

endmodule

`default_nettype wire

[hw/rtl/abd_center.sv]
// Decoded box centre along one axis, five register stages.
`timescale 1ns / 1ps
`default_nettype none

module abd_center
    import abd_pkg::*;
(
    input  wire logic                          clk,
    input  wire abd_pipe_t                     pipe,
    input  wire logic signed [COORD_WIDTH-1:0] lo,
    input  wire logic signed [COORD_WIDTH-1:0] hi,
    input  wire logic signed [RAW_WIDTH-1:0]   raw,
    input  wire logic        [VAR_WIDTH-1:0]   var_scale,
    output logic signed [CENTER_W-1:0]         center
);

    localparam int SW   = COORD_WIDTH + 1;  // sum and difference of corners
    localparam int TW   = 32;               // raw * variance
    localparam int OW   = 25;               // scaled offset, Q.20
    localparam int OSW  = OW + SW;          // offset times size
    localparam int SUMW = COORD_WIDTH + 27; // centre accumulation

    logic signed [TW-1:0]       t1_reg;
    logic signed [SW-1:0]       c2_1_reg;
    logic signed [SW-1:0]       s1_reg;
    logic signed [OSW-1:0]      os2_reg;
    logic signed [SW-1:0]       c2_2_reg;
    logic signed [CENTER_W-1:0] cen3_reg;
    logic signed [CENTER_W-1:0] cen4_reg;
    logic signed [CENTER_W-1:0] cen5_reg;

    logic signed [TW:0]         t_prod;
    logic signed [TW:0]         t_bias;
    logic signed [OW-1:0]       ofs;
    logic signed [SUMW-1:0]     acc;

    // Stage 1: scale the raw offset, form doubled centre and size
    assign t_prod = (TW + 1)'(raw) * (TW + 1)'(signed'({1'b0, var_scale}));

    // Stage 2: round to Q.20 and multiply by the anchor size
    assign t_bias = (TW + 1)'(t1_reg) + (TW + 1)'(64);
    assign ofs    = t_bias[OW+6:7];

    // Stage 3: centre = (c2 * 2^19 + o * s + 2^19) / 2^20, floored
    assign acc = (SUMW'(c2_2_reg) <<< 19) + SUMW'(os2_reg) + (SUMW'(1) <<< 19);

    always_ff @(posedge clk)
    begin
        if (pipe.en[0])
        begin
            t1_reg   <= t_prod[TW-1:0];
            c2_1_reg <= SW'(lo) + SW'(hi);
            s1_reg   <= SW'(hi) - SW'(lo);
        end
        if (pipe.en[1])
        begin
            os2_reg  <= OSW'(ofs) * OSW'(s1_reg);
            c2_2_reg <= c2_1_reg;
        end
        if (pipe.en[2])
        begin
            cen3_reg <= acc[SUMW-1:20];
        end
        // Delay to line up with the half size path
        if (pipe.en[3])
        begin
            cen4_reg <= cen3_reg;
        end
        if (pipe.en[4])
        begin
            cen5_reg <= cen4_reg;
        end
    end

    assign center = cen5_reg;

endmodule

`default_nettype wire

[hw/rtl/abd_half_size.sv]
// Signed half size along one axis, anchor size times exp of the log offset.
`timescale 1ns / 1ps
`default_nettype none

module abd_half_size
    import abd_pkg::*;
(
    input  wire logic                          clk,
    input  wire abd_pipe_t                     pipe,
    input  wire logic signed [COORD_WIDTH-1:0] lo,
    input  wire logic signed [COORD_WIDTH-1:0] hi,
    input  wire logic signed [RAW_WIDTH-1:0]   raw,
    input  wire logic        [VAR_WIDTH-1:0]   var_scale,
    output logic signed [HALF_W-1:0]           half
);

    localparam int SW  = COORD_WIDTH + 1;  // corner difference
    localparam int TW  = 32;               // raw * variance, Q.27
    localparam int LW  = 49;               // times log2(e)
    localparam int PW  = COORD_WIDTH + 17; // mantissa times size
    localparam int HMW = HALF_W - 1;       // half size magnitude

    logic signed [TW-1:0]  t1_reg;
    logic signed [SW-1:0]  s1_reg;
    logic signed [LW-1:0]  tl2_reg;
    logic signed [SW-1:0]  s2_reg;
    logic signed [5:0]     k3_reg;
    logic [16:0]           base3_reg;
    logic [24:0]           dr3_reg;
    logic [COORD_WIDTH-1:0] mag3_reg;
    logic                  neg3_reg;
    logic [PW-1:0]         p4_reg;
    logic signed [5:0]     k4_reg;
    logic                  neg4_reg;
    logic signed [HALF_W-1:0] half5_reg;

    logic signed [TW:0]    t_prod;
    logic signed [LW:0]    tl_prod;
    logic signed [21:0]    u;
    logic [3:0]            idx;
    logic [11:0]           frac;
    logic [COORD_WIDTH-1:0] mag;
    logic [16:0]           mant;
    logic signed [6:0]     e;
    logic [5:0]            sh_m1;
    logic [PW-1:0]         q;
    logic [PW:0]           q_inc;
    logic [HMW-1:0]        h;
    logic signed [HALF_W-1:0] hs;

    // Stage 1: scale the raw log offset
    assign t_prod = (TW + 1)'(raw) * (TW + 1)'(signed'({1'b0, var_scale}));

    // Stage 2: convert to base 2
    assign tl_prod = (LW + 1)'(t1_reg) * (LW + 1)'(LOG2E_Q16);

    // Stage 3: split into integer and fraction, table lookup
    assign u    = tl2_reg[LW-1:27];
    assign idx  = u[15:12];
    assign frac = u[11:0];
    assign mag  = s2_reg[SW-1] ? COORD_WIDTH'(-s2_reg) : COORD_WIDTH'(s2_reg);

    // Stage 4: interpolated mantissa
    assign mant = base3_reg + 17'(dr3_reg >> 12);

    // Stage 5: scale by 2^(k-17), right shifts round half up
    assign e     = 7'(k4_reg) - 7'sd17;
    assign sh_m1 = 6'(~e);
    assign q     = p4_reg >> sh_m1;
    assign q_inc = {1'b0, q} + (PW + 1)'(1);

    always_comb
    begin
        if (e[6])
        begin
            h = HMW'(q_inc[PW:1]);
        end
        else
        begin
            h = HMW'(p4_reg) << e[2:0];
        end
    end

    assign hs = signed'({1'b0, h});

    always_ff @(posedge clk)
    begin
        if (pipe.en[0])
        begin
            t1_reg <= t_prod[TW-1:0];
            s1_reg <= SW'(hi) - SW'(lo);
        end
        if (pipe.en[1])
        begin
            tl2_reg <= tl_prod[LW-1:0];
            s2_reg  <= s1_reg;
        end
        if (pipe.en[2])
        begin
            k3_reg    <= u[21:16];
            base3_reg <= POW2_BASE[idx];
            dr3_reg   <= 25'(POW2_STEP[idx]) * 25'(frac);
            mag3_reg  <= mag;
            neg3_reg  <= s2_reg[SW-1];
        end
        if (pipe.en[3])
        begin
            p4_reg   <= PW'(mant) * PW'(mag3_reg);
            k4_reg   <= k3_reg;
            neg4_reg <= neg3_reg;
        end
        if (pipe.en[4])
        begin
            half5_reg <= neg4_reg ? -hs : hs;
        end
    end

    assign half = half5_reg;

endmodule

`default_nettype wire

[hw/rtl/anchor_box_decoder.sv]
// An accepted input transaction passes through the six register stages in order;
// out_valid rises once its result sits in the output register, where it can be taken.
// Throughput: one anchor per cycle while unstalled; six register stages hold one item
// each; the deepest stage is a single multiplier (scaled log offset times log2(e)).
// A stall at the output backs the pipeline up stage by stage, losing nothing.
// Reset: pipeline empties, variance registers return to 0.1, 0.1, 0.2, 0.2.
`timescale 1ns / 1ps
`default_nettype none
`include "anchor_box_decoder_defines.svh"

module anchor_box_decoder
    import abd_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire abd_in_t                    in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output abd_out_t                        out_data,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [VAR_WIDTH-1:0]       cfg_data
);

    localparam int CW = HALF_W + 1;
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    abd_pipe_t pipe;

    logic [VAR_WIDTH-1:0] var_cx_reg;
    logic [VAR_WIDTH-1:0] var_cy_reg;
    logic [VAR_WIDTH-1:0] var_w_reg;
    logic [VAR_WIDTH-1:0] var_h_reg;

    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic signed [HALF_W-1:0]   hw;
    logic signed [HALF_W-1:0]   hh;

    logic [COORD_WIDTH:0] sat_xmin;
    logic [COORD_WIDTH:0] sat_ymin;
    logic [COORD_WIDTH:0] sat_xmax;
    logic [COORD_WIDTH:0] sat_ymax;

    abd_out_t out_data_reg;
    abd_out_t out_data_next;

    // Clip to the coordinate range; top bit flags a clip
    function automatic logic [COORD_WIDTH:0] clip(input logic signed [CW-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[CW-1:COORD_WIDTH-1];
        all_zero = ~|v[CW-1:COORD_WIDTH-1];
        if (all_one || all_zero)
        begin
            clip = {1'b0, v[COORD_WIDTH-1:0]};
        end
        else
        begin
            clip = {1'b1, (v[CW-1] ? COORD_MIN : COORD_MAX)};
        end
    endfunction

    // Variance registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_cx_reg <= 16'd6554;
            var_cy_reg <= 16'd6554;
            var_w_reg  <= 16'd13107;
            var_h_reg  <= 16'd13107;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_VAR_CENTER_X: var_cx_reg <= cfg_data;
                REG_VAR_CENTER_Y: var_cy_reg <= cfg_data;
                REG_VAR_WIDTH:    var_w_reg  <= cfg_data;
                REG_VAR_HEIGHT:   var_h_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    abd_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .pipe      (pipe)
    );

    abd_center u_center_x (
        .clk       (clk),
        .pipe      (pipe),
        .lo        (in_data.anchor_xmin),
        .hi        (in_data.anchor_xmax),
        .raw       (in_data.raw_dx),
        .var_scale (var_cx_reg),
        .center    (cx)
    );

    abd_center u_center_y (
        .clk       (clk),
        .pipe      (pipe),
        .lo        (in_data.anchor_ymin),
        .hi        (in_data.anchor_ymax),
        .raw       (in_data.raw_dy),
        .var_scale (var_cy_reg),
        .center    (cy)
    );

    abd_half_size u_half_w (
        .clk       (clk),
        .pipe      (pipe),
        .lo        (in_data.anchor_xmin),
        .hi        (in_data.anchor_xmax),
        .raw       (in_data.raw_dw),
        .var_scale (var_w_reg),
        .half      (hw)
    );

    abd_half_size u_half_h (
        .clk       (clk),
        .pipe      (pipe),
        .lo        (in_data.anchor_ymin),
        .hi        (in_data.anchor_ymax),
        .raw       (in_data.raw_dh),
        .var_scale (var_h_reg),
        .half      (hh)
    );

    // Stage 6: corners, clipped, into the output register
    assign sat_xmin = clip(CW'(cx) - CW'(hw));
    assign sat_ymin = clip(CW'(cy) - CW'(hh));
    assign sat_xmax = clip(CW'(cx) + CW'(hw));
    assign sat_ymax = clip(CW'(cy) + CW'(hh));

    always_comb
    begin
        out_data_next.box_xmin  = sat_xmin[COORD_WIDTH-1:0];
        out_data_next.box_ymin  = sat_ymin[COORD_WIDTH-1:0];
        out_data_next.box_xmax  = sat_xmax[COORD_WIDTH-1:0];
        out_data_next.box_ymax  = sat_ymax[COORD_WIDTH-1:0];
        out_data_next.saturated = sat_xmin[COORD_WIDTH] | sat_ymin[COORD_WIDTH]
                                | sat_xmax[COORD_WIDTH] | sat_ymax[COORD_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (pipe.en[NUM_STAGES-1])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_data = out_data_reg;

    // A full pipeline with a stalled output takes no new transaction
    `ABD_ASSERT_IMP(a_full_stall, (&pipe.vld) && !out_ready, !in_ready)

    // An accepted transaction occupies the first stage next cycle
    `ABD_ASSERT_NEXT(a_accept_fill, in_valid && in_ready, pipe.vld[0])

    // A clip flag implies some corner sits at a range limit
    `ABD_ASSERT_IMP(a_sat_limit, out_valid && out_data.saturated,
        out_data.box_xmin == COORD_MIN || out_data.box_xmin == COORD_MAX ||
        out_data.box_ymin == COORD_MIN || out_data.box_ymin == COORD_MAX ||
        out_data.box_xmax == COORD_MIN || out_data.box_xmax == COORD_MAX ||
        out_data.box_ymax == COORD_MIN || out_data.box_ymax == COORD_MAX)

endmodule

`default_nettype wire

[verif/anchor_box_decoder_tb.sv]
// Self-checking testbench for the anchor box decoder: directed table, random anchors, checker.
`timescale 1ns / 1ps

module anchor_box_decoder_tb;
    import abd_pkg::*;

    localparam int NUM_VAR_REGS = 4;
    localparam int NUM_CFG_SLOTS = 2 ** CFG_INDEX_WIDTH;
    localparam int REPORT_LIMIT = 10;
    // Keep a wide margin over the worst gap between transactions
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ONE = 8192;                  // 1.0 in Q2.13
    localparam int S16_MIN = -32768;
    localparam int S16_MAX = 32767;
    localparam logic [VAR_WIDTH-1:0] VAR_CENTRE_RESET = 16'd6554;
    localparam logic [VAR_WIDTH-1:0] VAR_SIZE_RESET   = 16'd13107;
    localparam logic [VAR_WIDTH-1:0] VAR_FULL         = 16'hFFFF;
    localparam longint HALF_Q20 = 64'sd524288;
    localparam longint LOG2E_FIX = 64'sd94548;
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // One row of the directed table
    typedef struct {
        abd_in_t  item;
        bit       has_box;
        abd_out_t box;
    } anchor_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    abd_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    abd_out_t out_data;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [VAR_WIDTH-1:0]       cfg_data;

    // Predictor state: variance registers and 2^(i/16) knots in Q.16
    logic [VAR_WIDTH-1:0] var_scale [NUM_VAR_REGS];
    longint exp2_knots [0:16] = '{
        65536, 68438, 71468, 74632, 77936, 81386, 84990, 88753,
        92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515,
        131072
    };

    abd_out_t    expected_boxes [$];
    anchor_row_t directed_rows [$];
    int  anchors_sent;
    int  boxes_seen;
    int  clipped_boxes;
    int  mismatch_count;
    int  settings_count;
    bit  tx_calm;

    anchor_box_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Decoded centre in Q.F: anchor centre moved by the scaled offset times the size
    function automatic longint centre_pos(input longint lo, input longint hi,
                                          input longint raw, input longint scale);
        longint offset;
        offset = (raw * scale + 64) >>> 7;
        return ((lo + hi) * HALF_Q20 + offset * (hi - lo) + HALF_Q20) >>> 20;
    endfunction

    // Signed half size: |size| times exp(raw * scale), exp via 2^x with a 16-segment table
    function automatic longint half_extent(input longint raw, input longint scale,
                                           input longint size);
        longint log2_arg;
        longint k;
        longint frac;
        longint mant;
        longint shift;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned half;
        int seg;
        log2_arg = (raw * scale * LOG2E_FIX) >>> 27;
        k = log2_arg >>> 16;
        frac = log2_arg - (k <<< 16);
        seg = int'(frac >>> 12);
        mant = exp2_knots[seg]
             + (((exp2_knots[seg + 1] - exp2_knots[seg]) * (frac & 4095)) >>> 12);
        mag = (size < 0) ? -size : size;
        prod = mant * mag;
        shift = k - 17;
        if (shift >= 0)
            half = prod << shift;
        else
            half = (prod + (64'd1 << (-shift - 1))) >> (-shift);
        return (size < 0) ? -longint'(half) : longint'(half);
    endfunction

    // Expected box for one anchor under the current variances
    function automatic abd_out_t predict_box(input abd_in_t a);
        longint cx;
        longint cy;
        longint hw;
        longint hh;
        longint corner [4];
        abd_out_t box;
        cx = centre_pos(a.anchor_xmin, a.anchor_xmax, a.raw_dx, var_scale[REG_VAR_CENTER_X]);
        cy = centre_pos(a.anchor_ymin, a.anchor_ymax, a.raw_dy, var_scale[REG_VAR_CENTER_Y]);
        hw = half_extent(a.raw_dw, var_scale[REG_VAR_WIDTH],
                         longint'(a.anchor_xmax) - longint'(a.anchor_xmin));
        hh = half_extent(a.raw_dh, var_scale[REG_VAR_HEIGHT],
                         longint'(a.anchor_ymax) - longint'(a.anchor_ymin));
        corner[0] = cx - hw;
        corner[1] = cy - hh;
        corner[2] = cx + hw;
        corner[3] = cy + hh;
        box.saturated = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (corner[i] > COORD_MAX)
            begin
                corner[i] = COORD_MAX;
                box.saturated = 1'b1;
            end
            else if (corner[i] < COORD_MIN)
            begin
                corner[i] = COORD_MIN;
                box.saturated = 1'b1;
            end
        end
        box.box_xmin = corner[0][COORD_WIDTH-1:0];
        box.box_ymin = corner[1][COORD_WIDTH-1:0];
        box.box_xmax = corner[2][COORD_WIDTH-1:0];
        box.box_ymax = corner[3][COORD_WIDTH-1:0];
        return box;
    endfunction

    function automatic abd_in_t anchor_item(input int x0, input int y0, input int x1,
                                            input int y1, input int dx, input int dy,
                                            input int dw, input int dh);
        abd_in_t a;
        a.anchor_xmin = COORD_WIDTH'(x0);
        a.anchor_ymin = COORD_WIDTH'(y0);
        a.anchor_xmax = COORD_WIDTH'(x1);
        a.anchor_ymax = COORD_WIDTH'(y1);
        a.raw_dx = RAW_WIDTH'(dx);
        a.raw_dy = RAW_WIDTH'(dy);
        a.raw_dw = RAW_WIDTH'(dw);
        a.raw_dh = RAW_WIDTH'(dh);
        return a;
    endfunction

    function automatic abd_out_t box_value(input int x0, input int y0, input int x1,
                                           input int y1, input bit clip);
        abd_out_t b;
        b.box_xmin = COORD_WIDTH'(x0);
        b.box_ymin = COORD_WIDTH'(y0);
        b.box_xmax = COORD_WIDTH'(x1);
        b.box_ymax = COORD_WIDTH'(y1);
        b.saturated = clip;
        return b;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input abd_in_t item, input bit has_box, input abd_out_t box);
        anchor_row_t row;
        row.item    = item;
        row.has_box = has_box;
        row.box     = box;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Mostly plausible anchors with small offsets, plus full-range noise and edge values
    function automatic abd_in_t random_anchor();
        int pick;
        int edges [7];
        abd_in_t a;
        int x0;
        int y0;
        int x1;
        int y1;
        edges = '{S16_MIN, S16_MAX, 0, -1, 1, ONE, -ONE};
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            x0 = $urandom_range(0, ONE);
            y0 = $urandom_range(0, ONE);
            x1 = x0 + $urandom_range(0, ONE);
            y1 = y0 + $urandom_range(0, ONE);
            if ($urandom_range(0, 9) == 0)
                a = anchor_item(x1, y1, x0, y0, 0, 0, 0, 0);
            else
                a = anchor_item(x0, y0, x1, y1, 0, 0, 0, 0);
            a.raw_dx = RAW_WIDTH'(int'($urandom_range(0, 8192)) - 4096);
            a.raw_dy = RAW_WIDTH'(int'($urandom_range(0, 8192)) - 4096);
            a.raw_dw = RAW_WIDTH'(int'($urandom_range(0, 8192)) - 4096);
            a.raw_dh = RAW_WIDTH'(int'($urandom_range(0, 8192)) - 4096);
        end
        else if (pick < 85)
        begin
            a = abd_in_t'({$urandom, $urandom, $urandom, $urandom});
        end
        else
        begin
            a = anchor_item(edges[$urandom_range(0, 6)], edges[$urandom_range(0, 6)],
                            edges[$urandom_range(0, 6)], edges[$urandom_range(0, 6)],
                            edges[$urandom_range(0, 6)], edges[$urandom_range(0, 6)],
                            edges[$urandom_range(0, 6)], edges[$urandom_range(0, 6)]);
        end
        return a;
    endfunction

    // Present one anchor after a random gap and hold it until the transaction completes
    task automatic send_anchor(input abd_in_t item, input bit has_box, input abd_out_t box);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_ready !== 1'b1);
        expected_boxes.insert(expected_boxes.size(), has_box ? box : predict_box(item));
        anchors_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_anchor(random_anchor(), 1'b0, '0);
    endtask

    // Sender pauses until every expected box is back, then lets the pipeline settle
    task automatic drain_boxes();
        in_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge clk);
        repeat (NUM_STAGES) @(posedge clk);
    endtask

    // Write all four variances, then scribble on the unused register slots
    task automatic program_variances(input logic [VAR_WIDTH-1:0] vcx,
                                     input logic [VAR_WIDTH-1:0] vcy,
                                     input logic [VAR_WIDTH-1:0] vw,
                                     input logic [VAR_WIDTH-1:0] vh);
        logic [VAR_WIDTH-1:0] vals [NUM_VAR_REGS];
        vals[REG_VAR_CENTER_X] = vcx;
        vals[REG_VAR_CENTER_Y] = vcy;
        vals[REG_VAR_WIDTH]    = vw;
        vals[REG_VAR_HEIGHT]   = vh;
        for (int i = 0; i < NUM_CFG_SLOTS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_INDEX_WIDTH-1:0];
            cfg_data  <= (i < NUM_VAR_REGS) ? vals[i] : VAR_WIDTH'($urandom);
            @(posedge clk);
            if (i < NUM_VAR_REGS)
                var_scale[i] = vals[i];
        end
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic compare_field(input string name, input logic signed [COORD_WIDTH:0] got,
                                 input logic signed [COORD_WIDTH:0] want);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch in box %0d, %s: expected %0d, got %0d",
                         boxes_seen, name, want, got);
        end
    endtask

    // Stimulus and phase control
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        var_scale[REG_VAR_CENTER_X] = VAR_CENTRE_RESET;
        var_scale[REG_VAR_CENTER_Y] = VAR_CENTRE_RESET;
        var_scale[REG_VAR_WIDTH]    = VAR_SIZE_RESET;
        var_scale[REG_VAR_HEIGHT]   = VAR_SIZE_RESET;
        settings_count = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, run under the reset variances
        // zero box; unit box; full-range box clips its far corners; inverted anchor
        add_row(anchor_item(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, box_value(0, 0, 0, 0, 1'b0));
        add_row(anchor_item(-ONE, -ONE, ONE, ONE, 0, 0, 0, 0), 1'b1,
                box_value(-ONE, -ONE, ONE, ONE, 1'b0));
        add_row(anchor_item(S16_MIN, S16_MIN, S16_MAX, S16_MAX, 0, 0, 0, 0), 1'b1,
                box_value(S16_MIN, S16_MIN, S16_MAX, S16_MAX, 1'b1));
        add_row(anchor_item(ONE, ONE, -ONE, -ONE, 0, 0, 0, 0), 1'b1,
                box_value(ONE, ONE, -ONE, -ONE, 1'b0));
        // each offset at its extremes on a unit anchor
        add_row(anchor_item(0, 0, ONE, ONE, S16_MAX, 0, 0, 0), 1'b0, '0);
        add_row(anchor_item(0, 0, ONE, ONE, S16_MIN, 0, 0, 0), 1'b0, '0);
        add_row(anchor_item(0, 0, ONE, ONE, 0, S16_MAX, 0, 0), 1'b0, '0);
        add_row(anchor_item(0, 0, ONE, ONE, 0, S16_MIN, 0, 0), 1'b0, '0);
        add_row(anchor_item(0, 0, ONE, ONE, 0, 0, S16_MAX, 0), 1'b0, '0);
        add_row(anchor_item(0, 0, ONE, ONE, 0, 0, S16_MIN, 0), 1'b0, '0);
        add_row(anchor_item(0, 0, ONE, ONE, 0, 0, 0, S16_MAX), 1'b0, '0);
        add_row(anchor_item(0, 0, ONE, ONE, 0, 0, 0, S16_MIN), 1'b0, '0);
        // full-range anchors with all offsets pinned
        add_row(anchor_item(S16_MIN, S16_MIN, S16_MAX, S16_MAX,
                            S16_MAX, S16_MAX, S16_MAX, S16_MAX), 1'b0, '0);
        add_row(anchor_item(S16_MIN, S16_MIN, S16_MAX, S16_MAX,
                            S16_MIN, S16_MIN, S16_MIN, S16_MIN), 1'b0, '0);
        add_row(anchor_item(S16_MAX, S16_MAX, S16_MIN, S16_MIN,
                            S16_MAX, S16_MIN, S16_MAX, S16_MIN), 1'b0, '0);
        add_row(anchor_item(S16_MAX, S16_MIN, S16_MAX, S16_MIN,
                            0, 0, S16_MAX, S16_MAX), 1'b0, '0);
        // alternating bit patterns and small magnitudes
        add_row(anchor_item(21845, 21845, -21846, -21846,
                            21845, -21846, 21845, -21846), 1'b0, '0);
        add_row(anchor_item(-21846, -21846, 21845, 21845,
                            -21846, 21845, -21846, 21845), 1'b0, '0);
        add_row(anchor_item(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0, '0);
        add_row(anchor_item(1, 1, 1, 1, 1, 1, 1, 1), 1'b0, '0);
        foreach (directed_rows[i])
            send_anchor(directed_rows[i].item, directed_rows[i].has_box, directed_rows[i].box);
        send_random(300);

        // zero variances: no offset, exp gives one
        drain_boxes();
        program_variances('0, '0, '0, '0);
        send_random(280);
        // largest variances
        drain_boxes();
        program_variances(VAR_FULL, VAR_FULL, VAR_FULL, VAR_FULL);
        send_random(280);
        // arbitrary variances
        drain_boxes();
        program_variances(VAR_WIDTH'($urandom), VAR_WIDTH'($urandom),
                          VAR_WIDTH'($urandom), VAR_WIDTH'($urandom));
        send_random(280);
        // mixed extremes
        drain_boxes();
        program_variances('0, VAR_FULL, VAR_FULL, '0);
        send_random(280);
        // back to the usual SSD variances
        drain_boxes();
        program_variances(VAR_CENTRE_RESET, VAR_CENTRE_RESET, VAR_SIZE_RESET, VAR_SIZE_RESET);
        send_random(280);

        // Drain, then leave room for any stray box
        drain_boxes();
        repeat (NUM_STAGES * 4) @(posedge clk);
        $display("Run covered %0d anchors under %0d variance settings; %0d boxes were clipped.",
                 anchors_sent, settings_count, clipped_boxes);
        $display("Boxes checked: %0d, mismatching fields: %0d", boxes_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Result side: random stalls, compare each box with the oldest prediction
    initial
    begin
        int stall;
        bit rx_calm;
        abd_out_t want;
        out_ready = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            boxes_seen++;
            if (out_data.saturated === 1'b1)
                clipped_boxes++;
            if (expected_boxes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected box %0d: nothing was pending", boxes_seen);
            end
            else
            begin
                want = expected_boxes.pop_front();
                compare_field("box_xmin", out_data.box_xmin, want.box_xmin);
                compare_field("box_ymin", out_data.box_ymin, want.box_ymin);
                compare_field("box_xmax", out_data.box_xmax, want.box_xmax);
                compare_field("box_ymax", out_data.box_ymax, want.box_ymax);
                compare_field("saturated", out_data.saturated, want.saturated);
            end
        end
    end

    // Watchdog: abort if no transaction moves on either side for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/abd_pkg.sv
hw/rtl/abd_pipe_ctrl.sv
hw/rtl/abd_center.sv
hw/rtl/abd_half_size.sv
hw/rtl/anchor_box_decoder.sv
verif/anchor_box_decoder_tb.sv
